[design/pbcp_pkg.sv]
// ----------------------------------------------------------------------------
// pbcp_pkg
// Shared types and constants for the polyline to Bezier control point block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcp_pkg;

  localparam int COORD_W  = 24;
  localparam int SMOOTH_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED    = 2'd1;

  localparam logic [SMOOTH_W-1:0] SMOOTHING_RESET = 16'd13107;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

endpackage

`default_nettype wire

[design/polyline_bezier_control_points.sv]
// ----------------------------------------------------------------------------
// polyline_bezier_control_points
// Streams polyline points and emits one cubic Bezier segment per point, plus a closing segment on a closed path.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on in_valid/in_ready with final_point on the last one of a
//   polyline. Each point after the first releases the segment of the point
//   before it; the final point also releases its own segment and, with
//   closed_path set, a closing segment back to the first point.
//   Segments leave on out_valid/out_ready, one transaction per cycle while out_ready is high.
//   Configuration is written through cfg_valid/cfg_index/cfg_data, always
//   ready; write it only while the block is idle.
// Path: an accepted point is stored in the job register; its segments are
//   then computed one by one into the result register.
// Throughput: one point per cycle while out_ready is high and each point
//   causes at most one segment; a final point holds the job register until
//   its one to three segments have passed the single shared segment datapath.
// Reset: clears the window, the stored first points, the point count and
//   any pending job; smoothing returns to 13107 and closed_path to 0.
// Stall: while out_ready is low the result register holds, the job register
//   holds its pending segments and in_ready drops once a job is waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_bezier_control_points (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pbcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pbcp_pkg::CFG_DATA_W-1:0] cfg_data,
  // points
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pbcp_pkg::coord_t                point_x,
  input  wire pbcp_pkg::coord_t                point_y,
  input  wire logic                            final_point,
  // segments
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pbcp_pkg::coord_t                     ctrl_one_x,
  output pbcp_pkg::coord_t                     ctrl_one_y,
  output pbcp_pkg::coord_t                     ctrl_two_x,
  output pbcp_pkg::coord_t                     ctrl_two_y,
  output pbcp_pkg::coord_t                     end_x,
  output pbcp_pkg::coord_t                     end_y,
  output logic                                 last_segment
);
  import pbcp_pkg::*;

  // configuration registers
  logic [SMOOTH_W-1:0] smoothing;
  logic                closed_path;

  // stream state
  point_t              window_points [3];
  point_t              first_two_points [2];
  logic [1:0]          points_seen;

  // job register: pending segments A (previous point), B (final point),
  // C (closing segment) and the points they draw on
  logic [2:0]          job_mask;
  point_t              job_pts [4];
  point_t              job_first [2];
  logic                job_closed;

  logic                in_fire;
  logic                advance;
  point_t              pt;
  point_t              first_next;
  point_t              sel_m2, sel_m1, sel_cur, sel_nxt;
  logic                sel_last;
  logic [2:0]          mask_next;
  point_t              seg_one, seg_two;

  assign cfg_ready = 1'b1;
  assign pt.x      = point_x;
  assign pt.y      = point_y;

  assign advance = !out_valid || out_ready;

  always_comb begin
    mask_next = job_mask;
    if (job_mask[0]) begin
      mask_next[0] = 1'b0;
    end else if (job_mask[1]) begin
      mask_next[1] = 1'b0;
    end else begin
      mask_next[2] = 1'b0;
    end
  end

  assign in_ready = (job_mask == 3'b000) || (advance && (mask_next == 3'b000));
  assign in_fire  = in_valid && in_ready;

  // second stored point after this transaction
  assign first_next = (points_seen == 2'd0 || points_seen == 2'd1) ? pt : first_two_points[1];

  // pick the lowest pending segment
  always_comb begin
    if (job_mask[0]) begin
      sel_m2   = job_pts[0];
      sel_m1   = job_pts[1];
      sel_cur  = job_pts[2];
      sel_nxt  = job_pts[3];
      sel_last = 1'b0;
    end else if (job_mask[1]) begin
      sel_m2   = job_pts[1];
      sel_m1   = job_pts[2];
      sel_cur  = job_pts[3];
      sel_nxt  = job_closed ? job_first[0] : job_pts[3];
      sel_last = !job_closed;
    end else begin
      sel_m2   = job_pts[2];
      sel_m1   = job_pts[3];
      sel_cur  = job_first[0];
      sel_nxt  = job_first[1];
      sel_last = 1'b1;
    end
  end

  pbcp_segment u_segment (
    .smoothing (smoothing),
    .m2        (sel_m2),
    .m1        (sel_m1),
    .cur       (sel_cur),
    .nxt       (sel_nxt),
    .ctrl_one  (seg_one),
    .ctrl_two  (seg_two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing   <= SMOOTHING_RESET;
      closed_path <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SMOOTHING: smoothing   <= cfg_data[SMOOTH_W-1:0];
        REG_CLOSED:    closed_path <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) window_points[i] <= '0;
      first_two_points[0] <= '0;
      first_two_points[1] <= '0;
      points_seen         <= 2'd0;
      job_mask            <= 3'b000;
    end else begin
      if (!in_fire && advance && job_mask != 3'b000) begin
        job_mask <= mask_next;
      end
      if (in_fire) begin
        if (points_seen == 2'd0) begin
          for (int i = 0; i < 3; i++) window_points[i] <= pt;
          first_two_points[0] <= pt;
          for (int i = 0; i < 4; i++) job_pts[i] <= pt;
          job_first[0] <= pt;
        end else begin
          window_points[0] <= window_points[1];
          window_points[1] <= window_points[2];
          window_points[2] <= pt;
          for (int i = 0; i < 3; i++) job_pts[i] <= window_points[i];
          job_pts[3]   <= pt;
          job_first[0] <= first_two_points[0];
        end
        first_two_points[1] <= first_next;
        job_first[1]        <= first_next;
        job_closed          <= closed_path;
        job_mask <= {final_point && closed_path, final_point, points_seen != 2'd0};
        if (final_point) begin
          points_seen <= 2'd0;
        end else if (points_seen != 2'd3) begin
          points_seen <= points_seen + 2'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= job_mask != 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && job_mask != 3'b000) begin
      ctrl_one_x   <= seg_one.x;
      ctrl_one_y   <= seg_one.y;
      ctrl_two_x   <= seg_two.x;
      ctrl_two_y   <= seg_two.y;
      end_x        <= sel_cur.x;
      end_y        <= sel_cur.y;
      last_segment <= sel_last;
    end
  end

  // a final point resets the count and queues its own and, on a closed path, the closing segment
  a_final_job : assert property (@(posedge clk) disable iff (rst)
    (in_fire && final_point) |=>
      (points_seen == 2'd0) && job_mask[1] && (job_mask[2] == job_closed))
    else $error("final point did not queue its segments");

  // any point after the first queues the pending segment of its predecessor
  a_pending_seg : assert property (@(posedge clk) disable iff (rst)
    (in_fire && points_seen != 2'd0) |=> job_mask[0])
    else $error("pending segment lost");

  // a new job is taken only when the old one is drained this cycle
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (in_fire && job_mask != 3'b000) |-> (advance && $onehot(job_mask)))
    else $error("job overwritten with segments pending");

endmodule

`default_nettype wire

[design/pbcp_segment.sv]
// ----------------------------------------------------------------------------
// pbcp_segment
// Control points of one cubic segment: c1 = m1 + s*(cur - m2),
// c2 = cur + s*(m1 - nxt), s unsigned Q0.16, rounded half up to whole coordinate units and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcp_segment (
  input  wire logic [pbcp_pkg::SMOOTH_W-1:0] smoothing,
  input  wire pbcp_pkg::point_t              m2,
  input  wire pbcp_pkg::point_t              m1,
  input  wire pbcp_pkg::point_t              cur,
  input  wire pbcp_pkg::point_t              nxt,
  output pbcp_pkg::point_t                   ctrl_one,
  output pbcp_pkg::point_t                   ctrl_two
);
  import pbcp_pkg::*;

  // base + round(s * (a - b)), saturated to the coordinate range
  function automatic coord_t scale_add(coord_t base, coord_t a, coord_t b,
                                       logic [SMOOTH_W-1:0] s);
    logic signed [COORD_W:0]          diff;
    logic signed [COORD_W+SMOOTH_W+1:0] prod;
    logic signed [COORD_W+1:0]        rnd;
    logic signed [COORD_W+2:0]        sum;
    coord_t                           res;
    diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    prod = diff * $signed({1'b0, s});
    rnd  = (COORD_W+2)'((prod + (COORD_W+SMOOTH_W+2)'(32768)) >>> SMOOTH_W);
    sum  = $signed({{3{base[COORD_W-1]}}, base}) + $signed({rnd[COORD_W+1], rnd});
    if (sum > $signed({{3{1'b0}}, COORD_MAX})) begin
      res = COORD_MAX;
    end else if (sum < $signed({{3{1'b1}}, COORD_MIN})) begin
      res = COORD_MIN;
    end else begin
      res = sum[COORD_W-1:0];
    end
    return res;
  endfunction

  assign ctrl_one.x = scale_add(m1.x, cur.x, m2.x, smoothing);
  assign ctrl_one.y = scale_add(m1.y, cur.y, m2.y, smoothing);
  assign ctrl_two.x = scale_add(cur.x, m1.x, nxt.x, smoothing);
  assign ctrl_two.y = scale_add(cur.y, m1.y, nxt.y, smoothing);

endmodule

`default_nettype wire
